[hw/rtl/jsu_pkg.sv]
// Shared types, character codes and helper functions for the JSON string unescape unit.
package jsu_pkg;

	localparam int MaxOut = 7;

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChU         = 8'h75;
	localparam logic [7:0] ChN         = 8'h6E;
	localparam logic [7:0] ChT         = 8'h74;
	localparam logic [7:0] ChR         = 8'h72;
	localparam logic [7:0] ChB         = 8'h62;
	localparam logic [7:0] ChF         = 8'h66;

	localparam logic [5:0] HiSurPrefix = 6'b110110;  // 0xD800..0xDBFF
	localparam logic [5:0] LoSurPrefix = 6'b110111;  // 0xDC00..0xDFFF

	// One hex digit lookup
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// UTF-8 encoding of one code point, byte 0 leaves first
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
	} utf8_t;

	// Decoded result group for one input transfer
	typedef struct packed {
		logic                    valid;  // at least one result, or the end marker
		logic [MaxOut-1:0][7:0]  bytes;
		logic [2:0]              cnt;    // results in the group, 1..7
		logic                    has;    // 0 for a bare end marker
		logic                    last;
	} bundle_t;

	function automatic hex_t hex_val(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		if (cp < 21'h80) begin
			r.bytes[0] = cp[7:0];
			r.n        = 3'd1;
		end else if (cp < 21'h800) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.n        = 3'd2;
		end else if (cp < 21'h10000) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.n        = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.n        = 3'd4;
		end
		return r;
	endfunction

endpackage

[hw/rtl/jsu_decode.sv]
// Escape decoder: holds the parse state and turns one byte into a group of output bytes.
module jsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       byte_in,
	input  logic             last_in,
	input  logic             adv,      // state commits this cycle
	output jsu_pkg::bundle_t bun
);

	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_ESC     = 3'd1;
	localparam logic [2:0] MODE_HEX     = 3'd2;
	localparam logic [2:0] MODE_HI_WAIT = 3'd3;
	localparam logic [2:0] MODE_HI_ESC  = 3'd4;
	localparam logic [2:0] MODE_LO_HEX  = 3'd5;

	logic [2:0]       mode_q, mode_n;
	logic [1:0]       cnt_q, cnt_n;
	logic [11:0]      hex_q, hex_n;
	logic [9:0]       high_q, high_n;
	logic [2:0][7:0]  chars_q, chars_n;

	always_comb begin
		jsu_pkg::hex_t   hv;
		jsu_pkg::utf8_t  a_enc, c_enc;
		logic [15:0]     nv;
		logic            a_en, refeed_norm, refeed_esc, c_byte_en, c_code_en;
		logic [1:0]      b_n;
		logic [7:0]      cb;
		logic [20:0]     c_cp;
		logic [2:0]      a_n, k;
		logic [3:0]      total;

		hv          = jsu_pkg::hex_val(byte_in);
		nv          = {hex_q, hv.val};
		a_en        = 1'b0;
		refeed_norm = 1'b0;
		refeed_esc  = 1'b0;
		c_byte_en   = 1'b0;
		c_code_en   = 1'b0;
		b_n         = 2'd0;
		cb          = byte_in;
		c_cp        = {5'd0, nv};
		mode_n      = mode_q;
		cnt_n       = cnt_q;
		hex_n       = hex_q;
		high_n      = high_q;
		chars_n     = chars_q;

		unique case (mode_q)
			MODE_ESC: begin
				refeed_esc = 1'b1;
			end
			MODE_HEX, MODE_LO_HEX: begin
				if (!hv.ok) begin
					// broken escape: digits go out literally, byte is decoded again
					a_en        = (mode_q == MODE_LO_HEX);
					b_n         = cnt_q;
					cnt_n       = 2'd0;
					hex_n       = '0;
					refeed_norm = 1'b1;
				end else if (cnt_q != 2'd3) begin
					for (int i = 0; i < 3; i++) begin
						if (cnt_q == 2'(i)) chars_n[i] = byte_in;
					end
					cnt_n = cnt_q + 2'd1;
					hex_n = nv[11:0];
				end else begin
					cnt_n = 2'd0;
					hex_n = '0;
					if (mode_q == MODE_LO_HEX && nv[15:10] == jsu_pkg::LoSurPrefix) begin
						c_code_en = 1'b1;
						c_cp      = 21'h10000 + {1'b0, high_q, nv[9:0]};
						mode_n    = MODE_NORMAL;
					end else begin
						a_en = (mode_q == MODE_LO_HEX);
						if (nv[15:10] == jsu_pkg::HiSurPrefix) begin
							high_n = nv[9:0];
							mode_n = MODE_HI_WAIT;
						end else begin
							c_code_en = 1'b1;
							mode_n    = MODE_NORMAL;
						end
					end
				end
			end
			MODE_HI_WAIT: begin
				if (byte_in == jsu_pkg::ChBackslash) begin
					mode_n = MODE_HI_ESC;
				end else begin
					a_en        = 1'b1;
					refeed_norm = 1'b1;
				end
			end
			MODE_HI_ESC: begin
				if (byte_in == jsu_pkg::ChU) begin
					mode_n = MODE_LO_HEX;
					cnt_n  = 2'd0;
					hex_n  = '0;
				end else begin
					a_en       = 1'b1;
					refeed_esc = 1'b1;
				end
			end
			default: begin
				refeed_norm = 1'b1;
			end
		endcase

		if (refeed_norm) begin
			if (byte_in == jsu_pkg::ChBackslash) begin
				mode_n = MODE_ESC;
			end else begin
				mode_n    = MODE_NORMAL;
				c_byte_en = 1'b1;
			end
		end
		if (refeed_esc) begin
			mode_n = MODE_NORMAL;
			if (byte_in == jsu_pkg::ChU) begin
				mode_n = MODE_HEX;
				cnt_n  = 2'd0;
				hex_n  = '0;
			end else begin
				c_byte_en = 1'b1;
				unique case (byte_in)
					jsu_pkg::ChN: cb = 8'h0A;
					jsu_pkg::ChT: cb = 8'h09;
					jsu_pkg::ChR: cb = 8'h0D;
					jsu_pkg::ChB: cb = 8'h08;
					jsu_pkg::ChF: cb = 8'h0C;
					default:      cb = byte_in;
				endcase
			end
		end

		// end of string: flush open hex digits or high surrogate, then start clean
		if (last_in) begin
			unique case (mode_n)
				MODE_HEX:     b_n = cnt_n;
				MODE_HI_WAIT: begin
					c_code_en = 1'b1;
					c_cp      = {5'd0, jsu_pkg::HiSurPrefix, high_n};
				end
				MODE_HI_ESC:  a_en = 1'b1;
				MODE_LO_HEX: begin
					a_en = 1'b1;
					b_n  = cnt_n;
				end
				default: ;
			endcase
			mode_n = MODE_NORMAL;
			cnt_n  = 2'd0;
			hex_n  = '0;
			high_n = '0;
		end

		a_enc = jsu_pkg::utf8_enc({5'd0, jsu_pkg::HiSurPrefix, high_q});
		if (c_code_en) begin
			c_enc = jsu_pkg::utf8_enc(c_cp);
		end else begin
			c_enc          = '0;
			c_enc.bytes[0] = cb;
			c_enc.n        = c_byte_en ? 3'd1 : 3'd0;
		end
		a_n = a_en ? 3'd3 : 3'd0;

		// pack high surrogate, literal digits and final piece in that order
		for (int i = 0; i < jsu_pkg::MaxOut; i++) begin
			k = 3'(i);
			if (k < a_n) begin
				bun.bytes[i] = a_enc.bytes[k[1:0]];
			end else begin
				k = k - a_n;
				if (k < {1'b0, b_n}) begin
					bun.bytes[i] = chars_n[k[1:0]];
				end else begin
					k = k - {1'b0, b_n};
					bun.bytes[i] = c_enc.bytes[k[1:0]];
				end
			end
		end

		total    = {1'b0, a_n} + {2'b0, b_n} + {1'b0, c_enc.n};
		bun.last = last_in;
		bun.has  = (total != 4'd0);
		bun.cnt  = total[2:0];
		bun.valid = bun.has || last_in;
		if (!bun.has) begin
			bun.bytes[0] = 8'h00;
			bun.cnt      = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			cnt_q  <= 2'd0;
			hex_q  <= '0;
			high_q <= '0;
		end else if (adv) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
			hex_q  <= hex_n;
			high_q <= high_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) chars_q <= chars_n;
	end

endmodule

[hw/rtl/jsu_outq.sv]
// Output register: holds one decoded group and sends its bytes one transfer at a time.
module jsu_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::bundle_t bun,
	output logic             can_load,
	output logic             tvalid,
	input  logic             tready,
	output logic [7:0]       tdata,
	output logic             tuser,
	output logic             tlast
);

	jsu_pkg::bundle_t bun_s2;
	logic             valid_s2;
	logic [2:0]       idx_q;
	logic             end_of_group, done;

	assign end_of_group = (idx_q == bun_s2.cnt - 3'd1);
	assign done         = valid_s2 && tready && end_of_group;
	assign can_load     = !valid_s2 || done;

	assign tvalid = valid_s2;
	assign tdata  = bun_s2.bytes[idx_q];
	assign tuser  = bun_s2.has;
	assign tlast  = bun_s2.last && end_of_group;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 3'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 3'd0;
		end else if (done) begin
			valid_s2 <= 1'b0;
			idx_q    <= 3'd0;
		end else if (valid_s2 && tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) bun_s2 <= bun;
	end

endmodule

[hw/rtl/json_string_unescape_utf8_unit.sv]
// JSON string unescape unit: streams string-body bytes in and UTF-8 decoded bytes out.
//
// Takes one raw byte of a JSON string body per input transfer (tlast marks the
// string's final byte) and returns the decoded bytes, one per output transfer.
// Escapes \n \t \r \b \f become control bytes, other escaped bytes pass as
// themselves, \uXXXX becomes UTF-8 (surrogate pairs are joined), and broken or
// cut-short \u escapes come out as their literal digits. A string whose final
// byte yields nothing ends with one transfer with tuser low and tdata zero.
// Timing: an input byte lands in an input register, is decoded combinationally
// into a group of zero to seven output bytes, and that group is loaded into the
// output register once it is free; the bytes show on the master side from the
// output register. The output register drains one byte per cycle while the
// master side is ready, and a following group that yields bytes waits until the
// current group is through; when every byte yields at most one result and the
// master side stays ready, one input transfer is taken every cycle. Bytes that
// yield nothing (a backslash, hex digits) pass without using the output
// register. Input ready depends combinationally on output ready.
module json_string_unescape_utf8_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] has_byte
	output logic       m_axis_tlast    // out_last
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             adv, can_load;
	jsu_pkg::bundle_t bun;

	// input stage moves on when its group is empty or the output register frees up
	assign adv           = valid_s1 && (!bun.valid || can_load);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.adv     (adv),
		.bun     (bun)
	);

	jsu_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv && bun.valid),
		.bun      (bun),
		.can_load (can_load),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.tdata    (m_axis_tdata),
		.tuser    (m_axis_tuser),
		.tlast    (m_axis_tlast)
	);

endmodule
